### hdl/mu3_pkg.sv
// Shared types, constants and register indexes for the 3-D max-unpooling scatter address core.
package mu3_pkg;

    localparam int MAX_SLICES = 1024;
    localparam int ADDR_BITS  = 32;
    localparam int SLICE_W    = $clog2(MAX_SLICES);
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int TGT_W      = 18;

    localparam logic [31:0] ADDR_MASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                        32'((64'd1 << ADDR_BITS) - 64'd1);

    localparam logic [CFG_IDX_W-1:0] CFG_IN_DEPTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_DEPTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD        = 3'd7;

    typedef struct packed {
        logic [8:0]  in_depth;
        logic [8:0]  in_height;
        logic [8:0]  in_width;
        logic [8:0]  out_depth;
        logic [8:0]  out_height;
        logic [8:0]  out_width;
        logic [23:0] stride_packed;
        logic [23:0] pad_packed;
    } t_cfg;

    typedef struct packed {
        logic [31:0] element_value;
        logic [7:0]  offset_depth;
        logic [7:0]  offset_height;
        logic [7:0]  offset_width;
        logic        first_item;
    } t_in_word;

    typedef struct packed {
        logic [31:0] write_address;
        logic [31:0] write_value;
        logic        write_enable;
        logic        error_seen;
        logic [31:0] error_address;
    } t_out_word;

    // Classified word handed from the front to the back through the queue.
    typedef struct packed {
        logic [31:0]             value;
        logic [31:0]             depth_term;
        logic signed [TGT_W-1:0] tgt_h;
        logic signed [TGT_W-1:0] tgt_w;
        logic                    in_range;
        logic                    first;
    } t_q_entry;

endpackage

### hdl/mu3_front.sv
// Front end: accepts input words, tracks position counters and classifies each target.
module mu3_front import mu3_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_data,
    input  logic     i_full,
    output logic     o_push,
    output t_q_entry o_entry
);

    logic [SLICE_W-1:0] r_slice, n_slice, slice_d;
    logic [7:0]         r_dpos, n_dpos, dpos_d;
    logic [7:0]         r_hpos, n_hpos, hpos_d;
    logic [7:0]         r_wpos, n_wpos, wpos_d;

    logic [8:0]         d_nx, h_nx, w_nx;
    logic               d_wrap, h_wrap, w_wrap;
    logic [SLICE_W:0]   s_nx;

    logic signed [TGT_W-1:0] tgt_d, tgt_h, tgt_w;
    logic                    in_d, in_h, in_w;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        slice_d = i_data.first_item ? '0 : r_slice;
        dpos_d  = i_data.first_item ? '0 : r_dpos;
        hpos_d  = i_data.first_item ? '0 : r_hpos;
        wpos_d  = i_data.first_item ? '0 : r_wpos;

        tgt_d = TGT_W'({10'd0, dpos_d} * {10'd0, i_cfg.stride_packed[7:0]})
              - TGT_W'(i_cfg.pad_packed[7:0]) + TGT_W'(i_data.offset_depth);
        tgt_h = TGT_W'({10'd0, hpos_d} * {10'd0, i_cfg.stride_packed[15:8]})
              - TGT_W'(i_cfg.pad_packed[15:8]) + TGT_W'(i_data.offset_height);
        tgt_w = TGT_W'({10'd0, wpos_d} * {10'd0, i_cfg.stride_packed[23:16]})
              - TGT_W'(i_cfg.pad_packed[23:16]) + TGT_W'(i_data.offset_width);

        in_d = !tgt_d[TGT_W-1] && (tgt_d[TGT_W-2:0] < (TGT_W-1)'(i_cfg.out_depth));
        in_h = !tgt_h[TGT_W-1] && (tgt_h[TGT_W-2:0] < (TGT_W-1)'(i_cfg.out_height));
        in_w = !tgt_w[TGT_W-1] && (tgt_w[TGT_W-2:0] < (TGT_W-1)'(i_cfg.out_width));

        o_entry.value      = i_data.element_value;
        o_entry.depth_term = 32'({{(32-SLICE_W){1'b0}}, slice_d} * {23'd0, i_cfg.out_depth})
                           + {{(32-TGT_W){tgt_d[TGT_W-1]}}, tgt_d};
        o_entry.tgt_h      = tgt_h;
        o_entry.tgt_w      = tgt_w;
        o_entry.in_range   = in_d && in_h && in_w;
        o_entry.first      = i_data.first_item;

        w_nx   = {1'b0, wpos_d} + 9'd1;
        h_nx   = {1'b0, hpos_d} + 9'd1;
        d_nx   = {1'b0, dpos_d} + 9'd1;
        s_nx   = {1'b0, slice_d} + (SLICE_W+1)'(1);
        w_wrap = (w_nx >= i_cfg.in_width)  || (w_nx > 9'd255);
        h_wrap = (h_nx >= i_cfg.in_height) || (h_nx > 9'd255);
        d_wrap = (d_nx >= i_cfg.in_depth)  || (d_nx > 9'd255);

        n_wpos  = w_wrap ? '0 : w_nx[7:0];
        n_hpos  = hpos_d;
        n_dpos  = dpos_d;
        n_slice = slice_d;
        if (w_wrap) begin
            n_hpos = h_wrap ? '0 : h_nx[7:0];
            if (h_wrap) begin
                n_dpos = d_wrap ? '0 : d_nx[7:0];
                if (d_wrap) begin
                    n_slice = (s_nx >= (SLICE_W+1)'(MAX_SLICES)) ? '0 : s_nx[SLICE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice <= '0;
            r_dpos  <= '0;
            r_hpos  <= '0;
            r_wpos  <= '0;
        end else if (o_push) begin
            r_slice <= n_slice;
            r_dpos  <= n_dpos;
            r_hpos  <= n_hpos;
            r_wpos  <= n_wpos;
        end
    end

endmodule

### hdl/mu3_fifo.sv
// Short queue that decouples the front end from the address back end.
module mu3_fifo import mu3_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    input  logic     i_pop,
    output t_q_entry o_head,
    output logic     o_empty,
    output logic     o_full
);

    t_q_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wptr, r_rptr;
    logic [Q_CNT_W-1:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH)) else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue popped while empty");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue pushed while full");

endmodule

### hdl/mu3_back.sv
// Back end: forms the flat address, applies the range result and keeps the error record.
module mu3_back import mu3_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_empty,
    input  t_q_entry  i_head,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    typedef struct packed {
        logic [31:0]             value;
        logic [31:0]             plane_term;
        logic signed [TGT_W-1:0] tgt_w;
        logic                    in_range;
        logic                    first;
    } t_s1;

    t_s1         r_s1;
    logic        r_s1v;
    logic        r_ov;
    t_out_word   r_out;
    logic        r_err;
    logic [31:0] r_bad;

    logic        out_go;
    logic [31:0] idx;
    logic        n_err;
    logic [31:0] n_bad;

    assign out_go  = r_s1v && (!r_ov || i_ready);
    assign o_pop   = !i_empty && (!r_s1v || out_go);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_comb begin
        idx   = (32'(r_s1.plane_term * {23'd0, i_cfg.out_width})
              + {{(32-TGT_W){r_s1.tgt_w[TGT_W-1]}}, r_s1.tgt_w}) & ADDR_MASK;
        n_err = (r_s1.first ? 1'b0 : r_err) || !r_s1.in_range;
        n_bad = !r_s1.in_range ? idx : (r_s1.first ? 32'd0 : r_bad);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1.value      <= i_head.value;
            r_s1.plane_term <= 32'(i_head.depth_term * {23'd0, i_cfg.out_height})
                             + {{(32-TGT_W){i_head.tgt_h[TGT_W-1]}}, i_head.tgt_h};
            r_s1.tgt_w      <= i_head.tgt_w;
            r_s1.in_range   <= i_head.in_range;
            r_s1.first      <= i_head.first;
        end
        if (out_go) begin
            r_out.write_address <= r_s1.in_range ? idx : 32'd0;
            r_out.write_value   <= r_s1.value;
            r_out.write_enable  <= r_s1.in_range;
            r_out.error_seen    <= n_err;
            r_out.error_address <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_ov  <= 1'b0;
            r_err <= 1'b0;
            r_bad <= '0;
        end else begin
            if (o_pop) begin
                r_s1v <= 1'b1;
            end else if (out_go) begin
                r_s1v <= 1'b0;
            end
            if (out_go) begin
                r_ov  <= 1'b1;
                r_err <= n_err;
                r_bad <= n_bad;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    a_drop_flags_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.write_enable) |-> o_data.error_seen)
        else $error("suppressed write without error flag");
    a_drop_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.write_enable) |-> (o_data.write_address == 32'd0))
        else $error("suppressed write carries an address");
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1v && !out_go) |=> r_s1v) else $error("stalled stage lost its word");

endmodule

### hdl/max_unpool3d_scatter_address_core.sv
// Top level: configuration registers, front end, queue and address back end.
// Each word passes the front end, queue, back-end stage and output register.
// One word per cycle unless stalled, as each stage refills as it passes one on.
// Output stalls back up through the two-entry queue before the input ready drops.
// Reset is synchronous and active low; it restores the default configuration and
// clears the position counters, the queue, the error record and all valid flags.
module max_unpool3d_scatter_address_core import mu3_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_word              i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_word             o_data
);

    t_cfg     r_cfg;
    logic     q_push, q_pop, q_empty, q_full;
    t_q_entry q_in, q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_depth      <= 9'd1;
            r_cfg.in_height     <= 9'd1;
            r_cfg.in_width      <= 9'd1;
            r_cfg.out_depth     <= 9'd1;
            r_cfg.out_height    <= 9'd1;
            r_cfg.out_width     <= 9'd1;
            r_cfg.stride_packed <= 24'h01_0101;
            r_cfg.pad_packed    <= 24'h00_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IN_DEPTH:   r_cfg.in_depth      <= i_cfg_data[8:0];
                CFG_IN_HEIGHT:  r_cfg.in_height     <= i_cfg_data[8:0];
                CFG_IN_WIDTH:   r_cfg.in_width      <= i_cfg_data[8:0];
                CFG_OUT_DEPTH:  r_cfg.out_depth     <= i_cfg_data[8:0];
                CFG_OUT_HEIGHT: r_cfg.out_height    <= i_cfg_data[8:0];
                CFG_OUT_WIDTH:  r_cfg.out_width     <= i_cfg_data[8:0];
                CFG_STRIDE:     r_cfg.stride_packed <= i_cfg_data;
                CFG_PAD:        r_cfg.pad_packed    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mu3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_entry (q_in)
    );

    mu3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    mu3_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (q_empty),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
